@@ hw/rtl/ablm_pkg.sv @@
// Shared types and constants for the audio block level meter.
package ablm_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int LEVEL_W   = 24;
    localparam int MAG_W     = 24;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int SUM_W     = 58;
    localparam int MAX_BLOCK = 4096;
    localparam int COUNT_W   = $clog2(MAX_BLOCK + 1);
    localparam int ROOT_W    = SUM_W / 2;
    localparam int REM_W     = ROOT_W + 1;
    localparam int SUB_W     = ROOT_W + 2;
    localparam int ITER_W    = $clog2(SUM_W);
    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DECAY_W   = LEVEL_W + 1;
    localparam int RECIP_W   = 24;
    localparam int DPROD_W   = DECAY_W - 2 + RECIP_W;
    localparam int DECAY_SHIFT = 26;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(8388608);
    localparam int DECAY_NUM = 19;
    localparam int DECAY_DEN = 20;
    localparam logic [RECIP_W-1:0] DECAY_RECIP = RECIP_W'(13421773);

    localparam logic MODE_PEAK = 1'b0;
    localparam logic MODE_RMS  = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_in_block;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] transient;
    } out_item_t;

endpackage

@@ hw/rtl/audio_block_level_meter_top.sv @@
// Block level meter: peak/sqrt(2) or RMS level and transient indicator per sample block.
// A sample that does not close a block passes through the square and accumulate states before
// the next sample is accepted. A closing sample then runs the finish, divide (RMS mode with a
// nonempty block only), square root, transient and output states, and waits in the output state while the output
// is stalled. One shared subtract and compare unit runs the 58-step restoring division and the 29-step square root.
// Synchronous active-low reset clears the mode, the accumulators, the history and the output valid.
module audio_block_level_meter_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  ablm_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ablm_pkg::out_item_t m_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQUARE = 3'd1;
    localparam logic [2:0] ST_ACCUM  = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_SQRT   = 3'd5;
    localparam logic [2:0] ST_TRANS  = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    logic [2:0]                           state_reg, state_next;
    logic                                 mode_reg, mode_next;
    logic [ablm_pkg::MAG_W-1:0]           peak_reg, peak_next;
    logic [ablm_pkg::SUM_W-1:0]           sum_reg, sum_next;
    logic [ablm_pkg::COUNT_W-1:0]         count_reg, count_next;
    logic [ablm_pkg::LEVEL_W-1:0]         prev_reg, prev_next;
    logic [ablm_pkg::LEVEL_W-1:0]         hold_reg, hold_next;
    logic [ablm_pkg::LEVEL_W-1:0]         level_reg, level_next;
    logic [ablm_pkg::MAG_W-1:0]           mag_reg, mag_next;
    logic                                 last_reg, last_next;
    logic [ablm_pkg::PROD_W-1:0]          sq_reg, sq_next;
    logic [ablm_pkg::SUM_W-1:0]           work_reg, work_next;
    logic [ablm_pkg::REM_W-1:0]           rem_reg, rem_next;
    logic [ablm_pkg::ROOT_W-1:0]          root_reg, root_next;
    logic [ablm_pkg::COUNT_W-1:0]         div_reg, div_next;
    logic [ablm_pkg::ITER_W-1:0]          iter_reg, iter_next;
    logic                                 m_valid_reg, m_valid_next;
    ablm_pkg::out_item_t                  m_data_reg, m_data_next;

    logic [ablm_pkg::MAG_W-1:0]           in_mag;
    logic [ablm_pkg::MAG_W-1:0]           mul_a;
    logic [ablm_pkg::PROD_W-1:0]          prod;
    logic [ablm_pkg::SUM_W:0]             sum_ext;
    logic [ablm_pkg::SUM_W-1:0]           sum_sat;
    logic [ablm_pkg::SUB_W-1:0]           sub_a, sub_b;
    logic [ablm_pkg::SUB_W:0]             sub_diff;
    logic                                 sub_ok;
    logic [ablm_pkg::LEVEL_W-1:0]         level_w;
    logic [ablm_pkg::LEVEL_W-1:0]         rise;
    logic [ablm_pkg::LEVEL_W-1:0]         rise_hold;
    logic [ablm_pkg::DECAY_W-1:0]         decay_sum;
    logic [ablm_pkg::DPROD_W-1:0]         decay_prod;
    logic [ablm_pkg::LEVEL_W-1:0]         hold_decay;
    logic                                 iter_done;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign in_mag = s_data.sample[ablm_pkg::SAMPLE_W-1]
                  ? (~s_data.sample + ablm_pkg::SAMPLE_W'(1)) : s_data.sample;

    assign mul_a = (state_reg == ST_FINISH) ? peak_reg : mag_reg;
    assign prod  = {{ablm_pkg::MAG_W{1'b0}}, mul_a} * {{ablm_pkg::MAG_W{1'b0}}, mul_a};

    assign sum_ext = {1'b0, sum_reg}
                   + {{(ablm_pkg::SUM_W + 1 - ablm_pkg::PROD_W){1'b0}}, sq_reg};
    assign sum_sat = sum_ext[ablm_pkg::SUM_W] ? {ablm_pkg::SUM_W{1'b1}}
                                              : sum_ext[ablm_pkg::SUM_W-1:0];

    always_comb begin
        if (state_reg == ST_DIV) begin
            sub_a = {{(ablm_pkg::SUB_W - ablm_pkg::COUNT_W - 1){1'b0}},
                     rem_reg[ablm_pkg::COUNT_W-1:0], work_reg[ablm_pkg::SUM_W-1]};
            sub_b = {{(ablm_pkg::SUB_W - ablm_pkg::COUNT_W){1'b0}}, div_reg};
        end else begin
            sub_a = {rem_reg[ablm_pkg::ROOT_W-1:0],
                     work_reg[ablm_pkg::SUM_W-1:ablm_pkg::SUM_W-2]};
            sub_b = {root_reg, 2'b01};
        end
    end

    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ok   = !sub_diff[ablm_pkg::SUB_W];

    assign level_w = (root_reg > ablm_pkg::ROOT_W'(ablm_pkg::FULL_SCALE))
                   ? ablm_pkg::FULL_SCALE : root_reg[ablm_pkg::LEVEL_W-1:0];
    assign rise      = level_w - prev_reg;
    assign rise_hold = (rise > hold_reg) ? rise : hold_reg;

    // hold * 19 / 20 = hold - ceil(hold / 20), quarter then reciprocal of five
    assign decay_sum  = {1'b0, hold_reg}
                      + ablm_pkg::DECAY_W'(ablm_pkg::DECAY_DEN - 1);
    assign decay_prod = ablm_pkg::DPROD_W'(decay_sum[ablm_pkg::DECAY_W-1:2])
                      * ablm_pkg::DPROD_W'(ablm_pkg::DECAY_RECIP);
    assign hold_decay = hold_reg
                      - ablm_pkg::LEVEL_W'(decay_prod[ablm_pkg::DPROD_W-1:ablm_pkg::DECAY_SHIFT]);

    assign iter_done  = (iter_reg == '0);

    always_comb begin
        state_next   = state_reg;
        mode_next    = cfg_we ? cfg_wdata : mode_reg;
        peak_next    = peak_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        prev_next    = prev_reg;
        hold_next    = hold_reg;
        level_next   = level_reg;
        mag_next     = mag_reg;
        last_next    = last_reg;
        sq_next      = sq_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        div_next     = div_reg;
        iter_next    = iter_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mag_next   = in_mag;
                    last_next  = s_data.last_in_block;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                sq_next    = prod;
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (count_reg < ablm_pkg::COUNT_W'(ablm_pkg::MAX_BLOCK)) begin
                    if (mag_reg > peak_reg) begin
                        peak_next = mag_reg;
                    end
                    sum_next   = sum_sat;
                    count_next = count_reg + ablm_pkg::COUNT_W'(1);
                end
                state_next = last_reg ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH: begin
                rem_next   = '0;
                root_next  = '0;
                if (mode_reg == ablm_pkg::MODE_PEAK) begin
                    work_next  = {{(ablm_pkg::SUM_W - ablm_pkg::PROD_W + 1){1'b0}},
                                  prod[ablm_pkg::PROD_W-1:1]};
                    iter_next  = ablm_pkg::ITER_W'(ablm_pkg::SQRT_STEPS - 1);
                    state_next = ST_SQRT;
                end else if (count_reg == '0) begin
                    work_next  = '0;
                    iter_next  = ablm_pkg::ITER_W'(ablm_pkg::SQRT_STEPS - 1);
                    state_next = ST_SQRT;
                end else begin
                    work_next  = sum_reg;
                    div_next   = count_reg;
                    iter_next  = ablm_pkg::ITER_W'(ablm_pkg::DIV_STEPS - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                work_next = {work_reg[ablm_pkg::SUM_W-2:0], sub_ok};
                rem_next  = sub_ok ? sub_diff[ablm_pkg::REM_W-1:0]
                                   : sub_a[ablm_pkg::REM_W-1:0];
                iter_next = iter_reg - ablm_pkg::ITER_W'(1);
                if (iter_done) begin
                    rem_next   = '0;
                    root_next  = '0;
                    iter_next  = ablm_pkg::ITER_W'(ablm_pkg::SQRT_STEPS - 1);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                work_next = {work_reg[ablm_pkg::SUM_W-3:0], 2'b00};
                rem_next  = sub_ok ? sub_diff[ablm_pkg::REM_W-1:0]
                                   : sub_a[ablm_pkg::REM_W-1:0];
                root_next = {root_reg[ablm_pkg::ROOT_W-2:0], sub_ok};
                iter_next = iter_reg - ablm_pkg::ITER_W'(1);
                if (iter_done) begin
                    state_next = ST_TRANS;
                end
            end
            ST_TRANS: begin
                level_next = level_w;
                if (prev_reg < level_w) begin
                    hold_next = (rise_hold > ablm_pkg::FULL_SCALE) ? ablm_pkg::FULL_SCALE
                                                                   : rise_hold;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.level     = level_reg;
                    m_data_next.transient = hold_reg;
                    prev_next   = level_reg;
                    hold_next   = hold_decay;
                    peak_next   = '0;
                    sum_next    = '0;
                    count_next  = '0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= 1'b0;
            peak_reg    <= '0;
            sum_reg     <= '0;
            count_reg   <= '0;
            prev_reg    <= '0;
            hold_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            peak_reg    <= peak_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            prev_reg    <= prev_next;
            hold_reg    <= hold_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        level_reg  <= level_next;
        mag_reg    <= mag_next;
        last_reg   <= last_next;
        sq_reg     <= sq_next;
        work_reg   <= work_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        div_reg    <= div_next;
        iter_reg   <= iter_next;
        m_data_reg <= m_data_next;
    end

endmodule

@@ bench/tb_audio_block_level_meter_top.sv @@
// Self-checking testbench for the audio block level meter: directed and random sample blocks.
`timescale 1ns / 1ps

module tb_audio_block_level_meter_top;

    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT   = 5000;
    localparam int SQUEEZE_LEN   = 400;
    localparam logic [63:0] SUM_CAP = (64'd1 << ablm_pkg::SUM_W) - 64'd1;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_wdata = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    ablm_pkg::in_item_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    ablm_pkg::out_item_t m_data;

    ablm_pkg::in_item_t  sample_queue[$];
    ablm_pkg::out_item_t level_due[$];

    bit                           mode_now   = ablm_pkg::MODE_PEAK;
    logic [ablm_pkg::MAG_W-1:0]   peak_mag   = '0;
    logic [63:0]                  sq_sum     = '0;
    int                           n_samples  = 0;
    logic [ablm_pkg::LEVEL_W-1:0] prev_level = '0;
    logic [ablm_pkg::LEVEL_W-1:0] hold_level = '0;

    bit quiet    = 1'b0;
    bit squeezed = 1'b0;
    int failures = 0;
    int results_seen = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int squeeze_left = 0;
    int idle_cycles  = 0;

    audio_block_level_meter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [31:0] int_root(input logic [63:0] v);
        logic [31:0] r;
        logic [31:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if (64'(t) * 64'(t) <= v) r = t;
        end
        return r;
    endfunction

    task automatic meter_sample(input ablm_pkg::in_item_t it);
        logic [ablm_pkg::MAG_W-1:0]   mag;
        logic [63:0]                  sq;
        logic [31:0]                  root;
        logic [ablm_pkg::LEVEL_W-1:0] lvl;
        ablm_pkg::out_item_t          res;
        mag = it.sample[ablm_pkg::SAMPLE_W-1] ? (~it.sample + 24'd1) : it.sample;
        if (n_samples < ablm_pkg::MAX_BLOCK) begin
            sq = 64'(mag) * 64'(mag);
            if (mag > peak_mag) peak_mag = mag;
            sq_sum = (sq_sum > SUM_CAP - sq) ? SUM_CAP : sq_sum + sq;
            n_samples++;
        end
        if (it.last_in_block) begin
            if (mode_now == ablm_pkg::MODE_PEAK)
                root = int_root((64'(peak_mag) * 64'(peak_mag)) >> 1);
            else if (n_samples != 0) root = int_root(sq_sum / 64'(n_samples));
            else root = '0;
            lvl = (root > 32'(ablm_pkg::FULL_SCALE)) ? ablm_pkg::FULL_SCALE
                                                     : root[ablm_pkg::LEVEL_W-1:0];
            if (prev_level < lvl) begin
                if (lvl - prev_level > hold_level) hold_level = lvl - prev_level;
                if (hold_level > ablm_pkg::FULL_SCALE) hold_level = ablm_pkg::FULL_SCALE;
            end
            res.level     = lvl;
            res.transient = hold_level;
            level_due = {level_due, res};
            prev_level = lvl;
            hold_level = ablm_pkg::LEVEL_W'((64'(hold_level) * ablm_pkg::DECAY_NUM)
                                            / ablm_pkg::DECAY_DEN);
            peak_mag  = '0;
            sq_sum    = '0;
            n_samples = 0;
        end
    endtask

    task automatic queue_sample(input logic signed [ablm_pkg::SAMPLE_W-1:0] s, input bit last);
        ablm_pkg::in_item_t it;
        it.sample        = s;
        it.last_in_block = last;
        sample_queue = {sample_queue, it};
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (sample_queue.size() != 0 || s_valid || level_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_mode(input bit m);
        cfg_wdata <= m;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        mode_now = m;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) meter_sample(s_data);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(1, 16) - 1;
                    s_valid <= 1'b0;
                end else if (sample_queue.size() > 0) begin
                    s_data  <= sample_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (level_due.size() == 0) begin
                    $error("result with no level pending: level %0d transient %0d",
                           m_data.level, m_data.transient);
                    failures++;
                end else begin
                    ablm_pkg::out_item_t want;
                    want = level_due.pop_front();
                    if (m_data.level !== want.level) begin
                        $error("level: expected %0d, actual %0d", want.level, m_data.level);
                        failures++;
                    end
                    if (m_data.transient !== want.transient) begin
                        $error("transient: expected %0d, actual %0d",
                               want.transient, m_data.transient);
                        failures++;
                    end
                end
            end
            if (squeeze_left > 0) begin
                squeeze_left--;
                m_ready <= 1'b0;
            end else if (!squeezed && !quiet && results_seen >= 8 && m_valid
                         && sample_queue.size() > 60) begin
                squeezed     = 1'b1;
                squeeze_left = SQUEEZE_LEN - 1;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int len;
        int bits;
        int queued;
        logic [ablm_pkg::SAMPLE_W-1:0] raw;
        logic signed [ablm_pkg::SAMPLE_W-1:0] s;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        set_mode(ablm_pkg::MODE_PEAK);

        // peak mode: extremes, sign handling, decay after a large rise
        queue_sample(24'sh000000, 1'b1);
        queue_sample(24'sh7FFFFF, 1'b1);
        queue_sample(24'sh800000, 1'b1);
        queue_sample(24'sh000001, 1'b0);
        queue_sample(24'shFFFFFF, 1'b1);
        queue_sample(24'sd100, 1'b0);
        queue_sample(-24'sd5000, 1'b0);
        queue_sample(24'sd4000, 1'b1);
        queue_sample(24'sh800000, 1'b0);
        queue_sample(24'sh7FFFFF, 1'b0);
        queue_sample(24'sh000000, 1'b1);
        wait_idle();

        // RMS mode: full scale, silence, smallest step
        set_mode(ablm_pkg::MODE_RMS);
        queue_sample(24'sh800000, 1'b0);
        queue_sample(24'sh800000, 1'b0);
        queue_sample(24'sh800000, 1'b1);
        queue_sample(24'sh000000, 1'b1);
        queue_sample(24'sh000001, 1'b1);
        queue_sample(24'sh7FFFFF, 1'b0);
        queue_sample(24'shFFFFFF, 1'b1);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            if (p == 7) quiet = 1'b1;
            set_mode((p % 2 == 0) ? ablm_pkg::MODE_PEAK : ablm_pkg::MODE_RMS);
            queued = 0;
            while (queued < 96) begin
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 200)
                                                   : $urandom_range(1, 12);
                bits = $urandom_range(1, ablm_pkg::SAMPLE_W);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 15) == 0) begin
                        case ($urandom_range(0, 4))
                            0:       s = 24'sh7FFFFF;
                            1:       s = 24'sh800000;
                            2:       s = 24'sh000000;
                            3:       s = 24'shFFFFFF;
                            default: s = 24'sh000001;
                        endcase
                    end else begin
                        raw = ablm_pkg::SAMPLE_W'($urandom);
                        s   = $signed(raw) >>> (ablm_pkg::SAMPLE_W - bits);
                    end
                    queue_sample(s, k == len - 1);
                end
                queued += len;
            end
            wait_idle();
        end

        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ablm_pkg.sv
hw/rtl/audio_block_level_meter_top.sv
bench/tb_audio_block_level_meter_top.sv
